/* hdl/sorted_frame_index_table_macros.svh */
// assertion macros shared by the sorted frame index table
`ifndef SORTED_FRAME_INDEX_TABLE_MACROS_SVH
`define SORTED_FRAME_INDEX_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFIT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfit assertion failed");

// next-cycle implication, checked out of reset
`define SFIT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfit assertion failed");

`endif

/* hdl/sfit_pkg.sv */
// shared types and constants of the sorted frame index table
package sfit_pkg;

    localparam int FRAME_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int OUT_H_W    = 32;
    localparam int MOD_STEPS  = FRAME_W + 1;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS + 1);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd5;

    // input item kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // control state codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic               cmp_en;
        logic               ins_en;
        logic [FRAME_W-1:0] key;
    } t_cell_ctrl;

endpackage

/* hdl/sfit_cell.sv */
// one table cell: holds an entry, compares it with the key, shifts on insert
module sfit_cell #(
    parameter int HANDLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sfit_pkg::t_cell_ctrl           i_ctrl,
    input  logic [HANDLE_BITS-1:0]         i_new_handle,
    input  logic                           i_prev_valid,
    input  logic [sfit_pkg::FRAME_W-1:0]   i_prev_frame,
    input  logic [HANDLE_BITS-1:0]         i_prev_handle,
    input  logic                           i_prev_gt,
    output logic                           o_valid,
    output logic [sfit_pkg::FRAME_W-1:0]   o_frame,
    output logic [HANDLE_BITS-1:0]         o_handle,
    output logic                           o_gt,
    output logic                           o_eq
);

    logic                         r_valid;
    logic [sfit_pkg::FRAME_W-1:0] r_frame;
    logic [HANDLE_BITS-1:0]       r_handle;
    logic                         r_gt;
    logic                         r_eq;

    // valid flag: empty cells count as larger than any key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.ins_en) begin
            if (i_prev_gt) begin
                r_valid <= i_prev_valid;
            end else if (r_gt) begin
                r_valid <= 1'b1;
            end
        end
    end

    // entry payload: take the neighbor's entry or the new one
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en) begin
            if (i_prev_gt) begin
                r_frame  <= i_prev_frame;
                r_handle <= i_prev_handle;
            end else if (r_gt) begin
                r_frame  <= i_ctrl.key;
                r_handle <= i_new_handle;
            end
        end
    end

    // compare flags
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_gt <= !r_valid || (r_frame > i_ctrl.key);
            r_eq <= r_valid && (r_frame == i_ctrl.key);
        end
    end

    assign o_valid  = r_valid;
    assign o_frame  = r_frame;
    assign o_handle = r_handle;
    assign o_gt     = r_gt;
    assign o_eq     = r_eq;

endmodule

/* hdl/sorted_frame_index_table.sv */
// flow: an accepted item gets a compare pass of the cell chain (S_CMP), then a shift
// pass (S_UPD) that commits its result to the output register unless the output stalls;
// a tick whose wrap needs a true remainder first runs the bit-serial remainder unit (S_MOD)
// a new item is taken only when idle or as the last one commits; reset: synchronous,
// clears cell valid bits, play position, start flag, frame count to 1; stored entries need no clearing pass
module sorted_frame_index_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int HANDLE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sfit_pkg::FRAME_W-1:0]    i_cfg_frame_count,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [sfit_pkg::FRAME_W-1:0]    i_frame_number,
    input  logic [sfit_pkg::OUT_H_W-1:0]    i_buffer_handle,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sfit_pkg::STATUS_W-1:0]   o_status,
    output logic [sfit_pkg::FRAME_W-1:0]    o_play_position,
    output logic [sfit_pkg::OUT_H_W-1:0]    o_found_handle
);

`include "sorted_frame_index_table_macros.svh"

    localparam int FW = sfit_pkg::FRAME_W;

    logic [1:0]                     r_state;
    logic [FW-1:0]                  r_fc;
    logic [FW-1:0]                  r_pos;
    logic                           r_started;
    logic                           r_kind;
    logic                           r_range;
    logic [FW-1:0]                  r_key;
    logic [HANDLE_BITS-1:0]         r_new_handle;
    logic [FW-1:0]                  r_rem;
    logic [FW:0]                    r_div;
    logic [sfit_pkg::MOD_CNT_W-1:0] r_bit;
    logic                           r_out_valid;
    logic [sfit_pkg::STATUS_W-1:0]  r_out_status;
    logic [FW-1:0]                  r_out_pos;
    logic [sfit_pkg::OUT_H_W-1:0]   r_out_handle;

    logic                           w_in_acc;
    logic                           w_commit;
    logic [FW:0]                    w_p1;
    logic [FW:0]                    w_fc17;
    logic [FW:0]                    w_p1_sub;
    logic [FW:0]                    w_mod_t;
    logic                           w_mod_ge;
    logic [FW-1:0]                  w_mod_res;
    logic                           w_any_eq;
    logic [HANDLE_BITS-1:0]         w_hit_h;
    logic [sfit_pkg::STATUS_W-1:0]  n_status;
    logic                           w_ins;
    sfit_pkg::t_cell_ctrl           w_ctrl;

    logic [TABLE_DEPTH-1:0]         w_valid;
    logic [TABLE_DEPTH-1:0]         w_gt;
    logic [TABLE_DEPTH-1:0]         w_eq;
    logic [FW-1:0]                  w_frame  [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0]         w_handle [TABLE_DEPTH];

    // handshakes
    assign w_commit    = (r_state == sfit_pkg::S_UPD) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = !((r_state == sfit_pkg::S_IDLE) || w_commit);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = (r_state == sfit_pkg::S_IDLE);

    // next play position, fast wrap paths
    assign w_p1     = {1'b0, r_pos} + 1'b1;
    assign w_fc17   = {1'b0, r_fc};
    assign w_p1_sub = w_p1 - w_fc17;

    // one restoring remainder step
    assign w_mod_t   = {r_rem, r_div[FW]};
    assign w_mod_ge  = (w_mod_t >= w_fc17);
    assign w_mod_res = w_mod_ge ? FW'(w_mod_t - w_fc17) : w_mod_t[FW-1:0];

    // frame count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc <= FW'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fc <= i_cfg_frame_count;
        end
    end

    // control sequencer, position and remainder unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sfit_pkg::S_IDLE;
            r_pos     <= '0;
            r_started <= 1'b0;
        end else begin
            unique case (r_state)
                sfit_pkg::S_IDLE, sfit_pkg::S_UPD: begin
                    if (w_in_acc) begin
                        if (i_kind == sfit_pkg::KIND_TICK) begin
                            r_started <= 1'b1;
                            if (!r_started || (r_fc == '0)) begin
                                r_state <= sfit_pkg::S_CMP;
                                r_pos   <= '0;
                                r_key   <= '0;
                            end else if (w_p1 < w_fc17) begin
                                r_state <= sfit_pkg::S_CMP;
                                r_pos   <= w_p1[FW-1:0];
                                r_key   <= w_p1[FW-1:0];
                            end else if (w_p1_sub < w_fc17) begin
                                r_state <= sfit_pkg::S_CMP;
                                r_pos   <= w_p1_sub[FW-1:0];
                                r_key   <= w_p1_sub[FW-1:0];
                            end else begin
                                r_state <= sfit_pkg::S_MOD;
                                r_rem   <= '0;
                                r_div   <= w_p1;
                                r_bit   <= sfit_pkg::MOD_CNT_W'(sfit_pkg::MOD_STEPS);
                            end
                        end else begin
                            r_state <= sfit_pkg::S_CMP;
                            r_key   <= i_frame_number;
                        end
                    end else if (w_commit) begin
                        r_state <= sfit_pkg::S_IDLE;
                    end
                end
                sfit_pkg::S_MOD: begin
                    r_rem <= w_mod_res;
                    r_div <= {r_div[FW-1:0], 1'b0};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == sfit_pkg::MOD_CNT_W'(1)) begin
                        r_pos   <= w_mod_res;
                        r_key   <= w_mod_res;
                        r_state <= sfit_pkg::S_CMP;
                    end
                end
                sfit_pkg::S_CMP: begin
                    r_state <= sfit_pkg::S_UPD;
                end
                default: begin
                    r_state <= sfit_pkg::S_IDLE;
                end
            endcase
        end
    end

    // item payload captured at accept
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind       <= i_kind;
            r_range      <= (i_frame_number >= r_fc);
            r_new_handle <= HANDLE_BITS'(i_buffer_handle);
        end
    end

    // cell chain
    assign w_ctrl.cmp_en = (r_state == sfit_pkg::S_CMP);
    assign w_ctrl.ins_en = w_ins;
    assign w_ctrl.key    = r_key;

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            sfit_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new_handle  (r_new_handle),
                .i_prev_valid  (1'b0),
                .i_prev_frame  ('0),
                .i_prev_handle ('0),
                .i_prev_gt     (1'b0),
                .o_valid       (w_valid[gi]),
                .o_frame       (w_frame[gi]),
                .o_handle      (w_handle[gi]),
                .o_gt          (w_gt[gi]),
                .o_eq          (w_eq[gi])
            );
        end else begin : g_body
            sfit_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new_handle  (r_new_handle),
                .i_prev_valid  (w_valid[gi-1]),
                .i_prev_frame  (w_frame[gi-1]),
                .i_prev_handle (w_handle[gi-1]),
                .i_prev_gt     (w_gt[gi-1]),
                .o_valid       (w_valid[gi]),
                .o_frame       (w_frame[gi]),
                .o_handle      (w_handle[gi]),
                .o_gt          (w_gt[gi]),
                .o_eq          (w_eq[gi])
            );
        end
    end

    // match reduction: frames are unique, so at most one cell matches
    always_comb begin
        w_hit_h = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit_h = w_hit_h | ({HANDLE_BITS{w_eq[i]}} & w_handle[i]);
        end
    end
    assign w_any_eq = |w_eq;

    // result status and insert decision
    always_comb begin
        w_ins = 1'b0;
        priority if (r_kind == sfit_pkg::KIND_TICK) begin
            n_status = w_any_eq ? sfit_pkg::ST_HIT : sfit_pkg::ST_MISS;
        end else if (r_range) begin
            n_status = sfit_pkg::ST_RANGE;
        end else if (w_any_eq) begin
            n_status = sfit_pkg::ST_DUP;
        end else if (w_valid[TABLE_DEPTH-1]) begin
            n_status = sfit_pkg::ST_FULL;
        end else begin
            n_status = sfit_pkg::ST_STORED;
            w_ins    = w_commit;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_status <= n_status;
            r_out_pos    <= r_pos;
            r_out_handle <= (n_status == sfit_pkg::ST_HIT) ?
                            sfit_pkg::OUT_H_W'(w_hit_h) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_play_position = r_out_pos;
    assign o_found_handle  = r_out_handle;

    // occupied cells always form a prefix of the chain
    `SFIT_ASSERT_IMP(a_valid_prefix, 1'b1, ((w_valid & (w_valid + 1'b1)) == '0))
    // a stored entry adds exactly one occupied cell
    `SFIT_ASSERT_NXT(a_insert_grows, w_ins, ($countones(w_valid) == $past($countones(w_valid)) + 1))
    // a tick leaves the position inside the frame range
    `SFIT_ASSERT_NXT(a_pos_in_range, (w_commit && (r_kind == sfit_pkg::KIND_TICK) && (r_fc != '0)), (r_pos < r_fc))

endmodule

/* test/tb_sorted_frame_index_table.sv */
// testbench for the sorted frame index table: stores, ticks and frame count changes
`timescale 1ns / 1ps

module tb_sorted_frame_index_table;

    localparam int TBL_DEPTH    = 256;
    localparam int HANDLE_W     = 32;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int FRAME_W      = sfit_pkg::FRAME_W;
    localparam int STATUS_W     = sfit_pkg::STATUS_W;
    localparam int OUT_H_W      = sfit_pkg::OUT_H_W;

    typedef struct {
        logic                kind;
        logic [FRAME_W-1:0]  frame;
        logic [OUT_H_W-1:0]  handle;
    } t_frame_item;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  position;
        logic [OUT_H_W-1:0]  handle;
    } t_frame_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [FRAME_W-1:0]  cfg_frame_count = '0;
    logic                in_valid = 1'b0;
    logic                drv_kind = sfit_pkg::KIND_STORE;
    logic [FRAME_W-1:0]  drv_frame = '0;
    logic [OUT_H_W-1:0]  drv_handle = '0;
    logic                out_stall = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [FRAME_W-1:0]  o_play_position;
    logic [OUT_H_W-1:0]  o_found_handle;

    // predicted block state
    logic [FRAME_W-1:0]  tbl_frame [TBL_DEPTH];
    logic [HANDLE_W-1:0] tbl_handle [TBL_DEPTH];
    int                  tbl_count = 0;
    logic [FRAME_W-1:0]  play_pos = '0;
    bit                  played = 1'b0;
    logic [FRAME_W-1:0]  frames_total = 16'd1;

    t_frame_item         queued_items[$];
    t_frame_result       pending_results[$];
    logic [FRAME_W-1:0]  stored_history[$];
    int                  send_gap_pct = 0;
    int                  recv_stall_pct = 0;
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    int                  settings_used = 0;
    int                  status_seen [8];
    int                  idle_cycles = 0;

    sorted_frame_index_table #(
        .TABLE_DEPTH(TBL_DEPTH),
        .HANDLE_BITS(HANDLE_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_frame_count(cfg_frame_count),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(drv_kind),
        .i_frame_number(drv_frame),
        .i_buffer_handle(drv_handle),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_status(o_status),
        .o_play_position(o_play_position),
        .o_found_handle(o_found_handle)
    );

    // clock
    always begin
        #5 i_clk = ~i_clk;
    end

    // predict the result of one item and update the shadow table
    function automatic t_frame_result frame_table_result(input logic kind,
                                                         input logic [FRAME_W-1:0] frame,
                                                         input logic [OUT_H_W-1:0] handle);
        t_frame_result r;
        int            slot;
        bit            dup;
        bit            hit;
        r.handle = '0;
        if (kind == sfit_pkg::KIND_STORE) begin
            slot = tbl_count;
            dup  = 1'b0;
            if (frame >= frames_total) begin
                r.status = sfit_pkg::ST_RANGE;
            end else begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_frame[i] == frame) dup = 1'b1;
                    if (tbl_frame[i] > frame && slot == tbl_count) slot = i;
                end
                if (dup) begin
                    r.status = sfit_pkg::ST_DUP;
                end else if (tbl_count >= TBL_DEPTH) begin
                    r.status = sfit_pkg::ST_FULL;
                end else begin
                    // shift the tail up by one and drop the entry in its slot
                    for (int i = tbl_count; i > slot; i--) begin
                        tbl_frame[i]  = tbl_frame[i-1];
                        tbl_handle[i] = tbl_handle[i-1];
                    end
                    tbl_frame[slot]  = frame;
                    tbl_handle[slot] = handle[HANDLE_W-1:0];
                    tbl_count++;
                    r.status = sfit_pkg::ST_STORED;
                end
            end
        end else begin
            // advance the play position, first tick after reset lands on frame 0
            if (!played || frames_total == '0) begin
                play_pos = '0;
            end else begin
                play_pos = FRAME_W'(({1'b0, play_pos} + 17'd1) % {1'b0, frames_total});
            end
            played = 1'b1;
            hit    = 1'b0;
            for (int i = 0; i < tbl_count; i++) begin
                if (!hit && tbl_frame[i] == play_pos) begin
                    hit      = 1'b1;
                    r.handle = OUT_H_W'(tbl_handle[i]);
                end
            end
            r.status = hit ? sfit_pkg::ST_HIT : sfit_pkg::ST_MISS;
        end
        r.position = play_pos;
        return r;
    endfunction

    // item driver
    always @(posedge i_clk) begin
        t_frame_item nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                pending_results.push_back(frame_table_result(drv_kind, drv_frame, drv_handle));
                items_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                if (queued_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = queued_items.pop_front();
                    in_valid   <= 1'b1;
                    drv_kind   <= nxt.kind;
                    drv_frame  <= nxt.frame;
                    drv_handle <= nxt.handle;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        t_frame_result exp_r;
        if (i_rst_n && o_out_valid && !out_stall) begin
            status_seen[o_status]++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d position %0d handle %h",
                         $time, o_status, o_play_position, o_found_handle);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, exp_r.status, o_status);
                    mismatch_count++;
                end
                if (o_play_position !== exp_r.position) begin
                    $display("%0t: play position expected %0d got %0d",
                             $time, exp_r.position, o_play_position);
                    mismatch_count++;
                end
                if (o_found_handle !== exp_r.handle) begin
                    $display("%0t: found handle expected %h got %h",
                             $time, exp_r.handle, o_found_handle);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // wait until every queued item has been sent and answered
    task automatic settle();
        while (queued_items.size() > 0 || in_valid || pending_results.size() > 0)
            @(negedge i_clk);
    endtask

    // drain, write a new frame count, pick the idling mix
    task automatic begin_setting(input int fc, input int stage);
        settle();
        @(posedge i_clk);
        cfg_valid       <= 1'b1;
        cfg_frame_count <= fc[FRAME_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid    <= 1'b0;
        frames_total = fc[FRAME_W-1:0];
        settings_used++;
        send_gap_pct   = (stage == 0) ? 30 : (stage == 1) ? 68 : 0;
        recv_stall_pct = (stage == 0) ? 68 : (stage == 1) ? 30 : 0;
        @(negedge i_clk);
    endtask

    task automatic add_item(input logic kind, input logic [FRAME_W-1:0] frame,
                            input logic [OUT_H_W-1:0] handle);
        t_frame_item it;
        it.kind   = kind;
        it.frame  = frame;
        it.handle = handle;
        queued_items.push_back(it);
    endtask

    // random mix of ticks and stores around the current frame count
    task automatic run_phase(input int fc, input int n_items, input int stage);
        logic [FRAME_W-1:0] frame;
        logic [OUT_H_W-1:0] handle;
        int                 pick;
        int                 asc;
        begin_setting(fc, stage);
        asc = 0;
        repeat (n_items) begin
            handle = $urandom;
            pick   = $urandom_range(15);
            if (pick == 0) handle = '0;
            if (pick == 1) handle = '1;
            pick = $urandom_range(99);
            if ($urandom_range(1)) begin
                add_item(sfit_pkg::KIND_TICK, FRAME_W'($urandom), handle);
            end else begin
                if (pick < 55 && fc > 0) begin
                    frame = FRAME_W'($urandom_range(fc - 1));
                end else if (pick < 65 && stored_history.size() > 0) begin
                    frame = stored_history[$urandom_range(stored_history.size() - 1)];
                end else if (pick < 72) begin
                    frame = (fc > 0 && $urandom_range(1)) ? FRAME_W'(fc - 1) : FRAME_W'(fc);
                end else if (pick < 80) begin
                    frame = FRAME_W'($urandom);
                end else begin
                    // ascending run exercises the append path
                    if (fc > 0) asc = (asc + $urandom_range(1, 3)) % fc;
                    frame = FRAME_W'(asc);
                end
                stored_history.push_back(frame);
                add_item(sfit_pkg::KIND_STORE, frame, handle);
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        settings_used  = 1;
        send_gap_pct   = 30;
        recv_stall_pct = 68;

        // reset frame count of one: first tick, duplicate, out of range
        add_item(sfit_pkg::KIND_TICK, '0, '0);
        add_item(sfit_pkg::KIND_STORE, 16'd0, 32'hFFFF_FFFF);
        add_item(sfit_pkg::KIND_STORE, 16'd0, 32'h0000_0000);
        add_item(sfit_pkg::KIND_STORE, 16'd1, 32'h1111_1111);
        add_item(sfit_pkg::KIND_STORE, 16'hFFFF, 32'h1234_5678);
        add_item(sfit_pkg::KIND_TICK, '0, '0);

        // frame count zero: every store out of range, tick stays on frame 0
        begin_setting(0, 0);
        add_item(sfit_pkg::KIND_STORE, 16'd0, 32'hDEAD_BEEF);
        add_item(sfit_pkg::KIND_STORE, 16'd5, 32'h0000_0001);
        add_item(sfit_pkg::KIND_TICK, '1, '1);

        // largest frame count: append, middle insert, boundary frames
        begin_setting(65535, 0);
        add_item(sfit_pkg::KIND_STORE, 16'hFFFE, 32'hA5A5_A5A5);
        add_item(sfit_pkg::KIND_STORE, 16'hFFFF, 32'h5A5A_5A5A);
        add_item(sfit_pkg::KIND_STORE, 16'h8000, 32'h5A5A_5A5A);
        add_item(sfit_pkg::KIND_STORE, 16'h0001, 32'h0000_0000);
        add_item(sfit_pkg::KIND_STORE, 16'h8000, 32'h0F0F_0F0F);
        add_item(sfit_pkg::KIND_TICK, '0, '0);
        add_item(sfit_pkg::KIND_TICK, '0, '0);
        add_item(sfit_pkg::KIND_TICK, '1, '1);

        // random phases, frame count lowered and raised, table fills up on the way
        run_phase(400, 300, 0);
        run_phase(40, 250, 0);
        run_phase(65535, 250, 1);
        run_phase(1, 100, 1);
        run_phase(300, 350, 2);
        run_phase(0, 50, 2);
        run_phase(1000, 325, 2);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items over %0d frame count settings, %0d table entries at the end",
                 items_sent, settings_used, tbl_count);
        $display("stored %0d, out of range %0d, duplicate %0d, full %0d, miss %0d, hit %0d",
                 status_seen[sfit_pkg::ST_STORED], status_seen[sfit_pkg::ST_RANGE],
                 status_seen[sfit_pkg::ST_DUP], status_seen[sfit_pkg::ST_FULL],
                 status_seen[sfit_pkg::ST_MISS], status_seen[sfit_pkg::ST_HIT]);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/sfit_pkg.sv
hdl/sfit_cell.sv
hdl/sorted_frame_index_table.sv
test/tb_sorted_frame_index_table.sv
